### hdl/sts_pkg.sv
package sts_pkg;

	// ASCII codes that the scanner looks for.
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_AT    = 8'h40;
	localparam logic [7:0] CASE_GAP   = 8'd32;

	// Digit run limits for the card check.
	localparam int RUN_W = 5;
	localparam logic [RUN_W-1:0] RUN_CAP   = 5'd20;
	localparam logic [RUN_W-1:0] CARD_MIN  = 5'd13;
	localparam logic [RUN_W-1:0] CARD_MAX  = 5'd19;

	// Health keywords, lowercase. The last character sits in the lowest byte.
	localparam int KW_COUNT   = 7;
	localparam int KW_MAX_LEN = 14;
	localparam int KW_CNT_W   = 3;
	localparam int DASHED_LEN = 11;

	typedef logic [KW_MAX_LEN*8-1:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"diagnosis", "patient", "medical record", "icd-10",
		"prescription", "health record", "mrn"
	};
	localparam int KW_LEN [KW_COUNT] = '{9, 7, 14, 6, 12, 13, 3};

	// Output classification.
	typedef enum logic [1:0] {
		LEVEL_PUBLIC       = 2'd0,
		LEVEL_CONFIDENTIAL = 2'd1,
		LEVEL_RESTRICTED   = 2'd2
	} level_t;

endpackage

### hdl/sensitive_text_scanner.sv
// Sensitive text scanner.
// Content enters one byte per item on the s_axis channel: tdata[7:0] holds the
// byte and tlast marks the final byte of the content. Only the final byte gives
// a result: one summary item on m_axis holding the Luhn-valid card count, the
// personal hit count (dashed identifiers plus email-like addresses), the number
// of distinct health keywords, the sensitivity level and a saturation flag.
// The block takes one byte per cycle unless a last byte waits for the output
// register. Each byte passes an input register and then updates the running
// state; after the last byte the summary is registered in the output register.
// This per-byte update is the single stage of work that sets that rate.
// After the summary is produced all running state returns to its reset value,
// so the next byte starts new content.
// Reset clears all running state and drops any waiting item. When the receiver
// stalls, the summary waits in the output register; bytes that give no result
// keep flowing, and only a further last byte waits until the register is free.
module sensitive_text_scanner
	import sts_pkg::*;
#(
	parameter int HISTORY_DEPTH = 14,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] card_count, [31:16] personal_count, [34:32] health_keyword_count,
	// [36:35] sensitivity_level, [37] count_saturated, [39:38] zero
	output logic [39:0] m_axis_tdata
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_NEAR = COUNT_MAX - 1'b1;

	typedef logic [HISTORY_DEPTH-1:0][7:0] hist_t;

	// Helpers for character classes and Luhn arithmetic.
	function automatic logic is_digit_f(input logic [7:0] b);
		return (b >= CHAR_0) && (b <= CHAR_9);
	endfunction

	function automatic logic is_alnum_f(input logic [7:0] b);
		return is_digit_f(b) || ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z)) ||
			((b >= CHAR_UP_A) && (b <= CHAR_UP_Z));
	endfunction

	function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
	endfunction

	function automatic logic card_ok(input logic [RUN_W-1:0] n, input logic [3:0] sp,
			input logic [3:0] sd);
		logic [3:0] s;
		s = n[0] ? sp : sd;
		return (n >= CARD_MIN) && (n <= CARD_MAX) && (s == 4'd0);
	endfunction

	// Shape ddd-dd-dddd with the oldest byte at index ten.
	function automatic logic dashed_f(input logic [DASHED_LEN-1:0][7:0] h);
		return is_digit_f(h[10]) && is_digit_f(h[9]) && is_digit_f(h[8]) &&
			(h[7] == CHAR_DASH) && is_digit_f(h[6]) && is_digit_f(h[5]) &&
			(h[4] == CHAR_DASH) && is_digit_f(h[3]) && is_digit_f(h[2]) &&
			is_digit_f(h[1]) && is_digit_f(h[0]);
	endfunction

	// Input stage.
	logic             s1_valid_q;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             out_free;
	logic             s1_fire;
	logic             in_fire;

	// Running state.
	logic                   in_run_q;
	logic [RUN_W-1:0]       run_digits_q;
	logic [3:0]             sum_plain_q;
	logic [3:0]             sum_doubled_q;
	hist_t                  hist_q;
	logic [COUNT_WIDTH-1:0] pending_q;
	logic [COUNT_WIDTH-1:0] confirmed_q;
	logic [COUNT_WIDTH-1:0] card_q;
	logic [COUNT_WIDTH-1:0] ident_q;
	logic [KW_COUNT-1:0]    kw_q;
	logic                   flag_q;
	logic                   dot_hold_q;
	logic                   prev_at_q;

	// Output register.
	logic                   m_valid_q;
	logic [15:0]            card_out_q;
	logic [15:0]            pers_out_q;
	logic [KW_CNT_W-1:0]    health_out_q;
	level_t                 level_out_q;
	logic                   sat_out_q;

	// Next-state values.
	logic                   is_digit;
	logic                   is_sep;
	logic [7:0]             c_low;
	logic [3:0]             dval;
	logic [4:0]             dval2;
	logic [3:0]             dbl;
	logic                   add_ok;
	logic                   run_end;
	logic                   in_run_n;
	logic [RUN_W-1:0]       run_digits_n;
	logic [3:0]             sum_plain_n;
	logic [3:0]             sum_doubled_n;
	hist_t                  hist_n;
	logic                   card_inc;
	logic                   card_flag;
	logic [COUNT_WIDTH-1:0] card_n;
	logic                   ident_inc;
	logic                   ident_flag;
	logic [COUNT_WIDTH-1:0] ident_n;
	logic                   at_hit;
	logic                   pend_flag;
	logic [COUNT_WIDTH-1:0] pending_n;
	logic [COUNT_WIDTH-1:0] conf_add;
	logic [COUNT_WIDTH:0]   conf_sum;
	logic                   conf_flag;
	logic [COUNT_WIDTH-1:0] confirmed_n;
	logic                   dot_hold_n;
	logic [KW_COUNT-1:0]    kw_hit;
	logic [KW_COUNT-1:0]    kw_n;
	logic                   flag_n;
	logic [COUNT_WIDTH:0]   pers_sum;
	logic [COUNT_WIDTH-1:0] pers_n;
	logic                   pers_flag;
	logic [KW_CNT_W-1:0]    health_n;
	level_t                 level_n;

	// Handshake: bytes without a result never wait for the output register.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_fire       = s1_valid_q && (!last_s1 || out_free);
	assign s_axis_tready = !s1_valid_q || s1_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Character classes of the current byte.
	always_comb begin
		is_digit = is_digit_f(byte_s1);
		is_sep   = (byte_s1 == CHAR_SPACE) || (byte_s1 == CHAR_DASH);
		c_low    = ((byte_s1 >= CHAR_UP_A) && (byte_s1 <= CHAR_UP_Z)) ?
			byte_s1 + CASE_GAP : byte_s1;
		dval     = byte_s1[3:0];
		dval2    = {dval, 1'b0};
		dbl      = (dval2 > 5'd9) ? 4'(dval2 - 5'd9) : dval2[3:0];
	end

	// Digit runs and their two Luhn sums.
	always_comb begin
		add_ok   = is_digit && (run_digits_q < RUN_CAP);
		run_end  = in_run_q && !is_digit && !is_sep;
		in_run_n = is_digit || (in_run_q && is_sep);
		run_digits_n  = run_digits_q;
		sum_plain_n   = sum_plain_q;
		sum_doubled_n = sum_doubled_q;
		if (run_end) begin
			run_digits_n  = '0;
			sum_plain_n   = '0;
			sum_doubled_n = '0;
		end else if (add_ok) begin
			run_digits_n  = run_digits_q + 1'b1;
			sum_plain_n   = add_mod10(sum_plain_q, run_digits_q[0] ? dbl : dval);
			sum_doubled_n = add_mod10(sum_doubled_q, run_digits_q[0] ? dval : dbl);
		end
		card_inc = run_end ? card_ok(run_digits_q, sum_plain_q, sum_doubled_q) :
			(last_s1 && in_run_n && card_ok(run_digits_n, sum_plain_n, sum_doubled_n));
		card_flag = card_inc && (card_q >= COUNT_NEAR);
		card_n    = card_inc ? (card_flag ? COUNT_MAX : card_q + 1'b1) : card_q;
	end

	// History of lowercased bytes, newest first.
	assign hist_n = {hist_q[HISTORY_DEPTH-2:0], c_low};

	// Dashed identifiers, ended by a non-digit or by the last byte.
	always_comb begin
		ident_inc  = (!is_digit && dashed_f(hist_q[DASHED_LEN-1:0])) ||
			(last_s1 && dashed_f(hist_n[DASHED_LEN-1:0]));
		ident_flag = ident_inc && (ident_q >= COUNT_NEAR);
		ident_n    = ident_inc ? (ident_flag ? COUNT_MAX : ident_q + 1'b1) : ident_q;
	end

	// Email hits: an at sign after an alphanumeric waits for a later dot.
	// A dot right after the at sign confirms that hit one byte later.
	always_comb begin
		at_hit    = (byte_s1 == CHAR_AT) && is_alnum_f(hist_q[0]);
		pend_flag = at_hit && (pending_q >= COUNT_NEAR);
		if (byte_s1 == CHAR_DOT) begin
			pending_n = '0;
		end else if (at_hit) begin
			pending_n = pend_flag ? COUNT_MAX : pending_q + 1'b1;
		end else begin
			pending_n = pending_q;
		end
		priority if (dot_hold_q) begin
			conf_add = COUNT_WIDTH'(1);
		end else if (byte_s1 == CHAR_DOT) begin
			conf_add = prev_at_q ? pending_q - 1'b1 : pending_q;
		end else begin
			conf_add = '0;
		end
		dot_hold_n  = (byte_s1 == CHAR_DOT) && prev_at_q;
		conf_sum    = {1'b0, confirmed_q} + {1'b0, conf_add};
		conf_flag   = (conf_sum >= {1'b0, COUNT_MAX}) && (conf_add != '0);
		confirmed_n = (conf_sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX :
			conf_sum[COUNT_WIDTH-1:0];
	end

	// Keywords ending at this byte.
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			kw_hit[k] = 1'b1;
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if ((j < KW_LEN[k]) && (hist_n[j] != KW_TEXT[k][j*8 +: 8])) begin
					kw_hit[k] = 1'b0;
				end
			end
		end
		kw_n = kw_q | kw_hit;
	end

	// Summary for the last byte.
	always_comb begin
		flag_n    = flag_q || card_flag || ident_flag || pend_flag || conf_flag;
		pers_sum  = {1'b0, ident_n} + {1'b0, confirmed_n};
		pers_flag = (pers_sum >= {1'b0, COUNT_MAX}) && (confirmed_n != '0);
		pers_n    = (pers_sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX :
			pers_sum[COUNT_WIDTH-1:0];
		health_n  = KW_CNT_W'($countones(kw_n));
		priority if ((card_n != '0) || (health_n != '0)) begin
			level_n = LEVEL_RESTRICTED;
		end else if (pers_n != '0) begin
			level_n = LEVEL_CONFIDENTIAL;
		end else begin
			level_n = LEVEL_PUBLIC;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			card_out_q   <= 16'(card_n);
			pers_out_q   <= 16'(pers_n);
			health_out_q <= health_n;
			level_out_q  <= level_n;
			sat_out_q    <= flag_n || pers_flag;
		end
	end

	// Control and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			m_valid_q     <= 1'b0;
			in_run_q      <= 1'b0;
			run_digits_q  <= '0;
			sum_plain_q   <= '0;
			sum_doubled_q <= '0;
			hist_q        <= '0;
			pending_q     <= '0;
			confirmed_q   <= '0;
			card_q        <= '0;
			ident_q       <= '0;
			kw_q          <= '0;
			flag_q        <= 1'b0;
			dot_hold_q    <= 1'b0;
			prev_at_q     <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire && last_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				if (last_s1) begin
					in_run_q      <= 1'b0;
					run_digits_q  <= '0;
					sum_plain_q   <= '0;
					sum_doubled_q <= '0;
					hist_q        <= '0;
					pending_q     <= '0;
					confirmed_q   <= '0;
					card_q        <= '0;
					ident_q       <= '0;
					kw_q          <= '0;
					flag_q        <= 1'b0;
					dot_hold_q    <= 1'b0;
					prev_at_q     <= 1'b0;
				end else begin
					in_run_q      <= in_run_n;
					run_digits_q  <= run_digits_n;
					sum_plain_q   <= sum_plain_n;
					sum_doubled_q <= sum_doubled_n;
					hist_q        <= hist_n;
					pending_q     <= pending_n;
					confirmed_q   <= confirmed_n;
					card_q        <= card_n;
					ident_q       <= ident_n;
					kw_q          <= kw_n;
					flag_q        <= flag_n;
					dot_hold_q    <= dot_hold_n;
					prev_at_q     <= at_hit;
				end
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, sat_out_q, level_out_q, health_out_q, pers_out_q,
		card_out_q};

	// A summary only ever follows a last byte in the input register.
	a_out_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(s1_valid_q && last_s1))
		else $error("summary produced without a last byte");

	// The running state is back at reset after a summary is produced.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (!in_run_q && (run_digits_q == '0) &&
			(pending_q == '0) && (card_q == '0) && (kw_q == '0) && !flag_q))
		else $error("running state not cleared after the last byte");

	// A held dot confirmation always follows a dot, which empties the queue.
	a_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dot_hold_q |-> ((pending_q == '0) && !prev_at_q))
		else $error("held confirmation with hits still pending");

	// A public summary carries no hits at all.
	a_public_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (level_out_q == LEVEL_PUBLIC)) |->
			((card_out_q == '0) && (pers_out_q == '0) && (health_out_q == '0)))
		else $error("public level with non-zero counts");

endmodule
